/* hw/rtl/header_name_value_parser_assert.svh */
// Assertion macros for the header name/value parser.
// Used by the top level; relies on the clk_i and rst_ni names of the including module.
`ifndef HEADER_NAME_VALUE_PARSER_ASSERT_SVH
`define HEADER_NAME_VALUE_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HNVP_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HNVP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hnvp_pkg.sv */
// Shared types, constants and character classes for the header name/value parser.
// No dependencies; imported by every module of the block.
package hnvp_pkg;

  // Width of the internal byte position counter and of the reported offsets.
  localparam int unsigned POS_WIDTH = 16;
  localparam int unsigned OUT_POS_W = 16;

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [OUT_POS_W-1:0] opos_t;

  localparam pos_t POS_MAX = {POS_WIDTH{1'b1}};

  // Verdict error codes.
  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_BLANK   = 3'd1,
    ERR_TERM    = 3'd2,
    ERR_NAME    = 3'd3,
    ERR_MISSING = 3'd4,
    ERR_TOKEN   = 3'd5,
    ERR_QUOTED  = 3'd6,
    ERR_LONG    = 3'd7
  } err_e;

  // Characters with a role in the grammar.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // One input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_input;
  } item_t;

  // One verdict word.
  typedef struct packed {
    logic  verdict_ok;
    err_e  error_code;
    opos_t name_start;
    opos_t name_length;
    logic  has_value;
    opos_t value_start;
    opos_t value_length;
    logic  value_quoted;
  } result_t;

  // Token characters: letters, digits and !#$%&'*+-.^_`|~
  function automatic logic is_token(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                     8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                     8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB};
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return c inside {CH_CR, CH_LF, CH_NUL};
  endfunction

  // Reduce an internal position to the reported offset width.
  function automatic opos_t to_opos(input pos_t x);
    logic [31:0] w;
    w = 32'(x);
    return w[OUT_POS_W-1:0];
  endfunction

endpackage

/* hw/rtl/header_name_value_parser.sv */
// Top level of the header name/value parser: input stage, grammar core, verdict register.
// Depends on hnvp_pkg, hnvp_in_reg, hnvp_parse_core and header_name_value_parser_assert.svh.

// The block takes one byte of a header parameter string per word and gives one
// verdict word when the string ends (last_byte_i set, or empty_input_i set, which
// ends the string without a byte). It accepts a word whenever in_stall_o is low:
// each byte goes from the input register through the grammar state machine, so the
// sustained rate is one byte per clock while the input is not stalled. The verdict
// is registered once the closing word leaves the input register. The verdict register
// lets the input keep streaming while a verdict waits; the input stalls only when a
// second string ends while the previous verdict is still stalled. Offsets count bytes
// from the string start, and the position counter saturates for very long strings.
module header_name_value_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 empty_input_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 verdict_ok_o,
  output logic [2:0]           error_code_o,
  output hnvp_pkg::opos_t      name_start_o,
  output hnvp_pkg::opos_t      name_length_o,
  output logic                 has_value_o,
  output hnvp_pkg::opos_t      value_start_o,
  output hnvp_pkg::opos_t      value_length_o,
  output logic                 value_quoted_o
);
  import hnvp_pkg::*;

  `include "header_name_value_parser_assert.svh"

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_ends;
  logic    advance;
  logic    out_load;
  result_t core_result;
  result_t res_q, res_d;
  logic    out_valid_q, out_valid_d;
  logic    rej_clean;

  assign in_item.data_byte   = data_byte_i;
  assign in_item.last_byte   = last_byte_i;
  assign in_item.empty_input = empty_input_i;

  // Input register.
  hnvp_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .take_i (!in_stall_o),
    .item_i (in_item),
    .valid_o(s1_valid),
    .item_o (s1_item)
  );

  // A word moves on unless it closes a string while the verdict register is blocked.
  assign s1_ends    = s1_item.last_byte | s1_item.empty_input;
  assign advance    = s1_valid && (!s1_ends || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid && !advance;
  assign out_load   = advance && s1_ends;

  // Grammar state machine.
  hnvp_parse_core u_parse_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .item_i   (s1_item),
    .result_o (core_result)
  );

  // Verdict register.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      res_d       = core_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_ok_o   = res_q.verdict_ok;
  assign error_code_o   = res_q.error_code;
  assign name_start_o   = res_q.name_start;
  assign name_length_o  = res_q.name_length;
  assign has_value_o    = res_q.has_value;
  assign value_start_o  = res_q.value_start;
  assign value_length_o = res_q.value_length;
  assign value_quoted_o = res_q.value_quoted;

  // A rejected verdict must carry an error code and no name or value.
  assign rej_clean = (error_code_o != ERR_NONE) && !has_value_o &&
                     (name_length_o == '0) && (name_start_o == '0);

  // An empty verdict register never holds back the input.
  `HNVP_CHECK(a_no_stall_when_empty, !out_valid_q, !in_stall_o, "stall while output empty")
  // A closing word that moves on shows up as a verdict in the next cycle.
  `HNVP_CHECK_NEXT(a_verdict_follows, out_load, out_valid_o, "closing word produced no verdict")
  // A rejected string carries an error code and no name or value.
  `HNVP_CHECK(a_reject_clean, out_valid_o && !verdict_ok_o, rej_clean, "reject has stray fields")
  // An accepted string carries no error code.
  `HNVP_CHECK(a_accept_clean, out_valid_o && verdict_ok_o, error_code_o == ERR_NONE, "ok with error")

endmodule

/* hw/rtl/hnvp_in_reg.sv */
// Input register stage of the header name/value parser.
// Depends on hnvp_pkg for the word type.
module hnvp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic           take_i,
  input  hnvp_pkg::item_t item_i,
  output logic           valid_o,
  output hnvp_pkg::item_t item_o
);
  import hnvp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;

  // A new word is taken whenever the stage is not stalled.
  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take_i) begin
      valid_d = valid_i;
      if (valid_i) begin
        item_d = item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hw/rtl/hnvp_parse_core.sv */
// Grammar state machine and position tracking of the header name/value parser.
// Depends on hnvp_pkg for types, error codes and character classes.
module hnvp_parse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  hnvp_pkg::item_t   item_i,
  output hnvp_pkg::result_t result_o
);
  import hnvp_pkg::*;

  // Parse phases.
  localparam logic [3:0] PH_LEAD     = 4'd0;
  localparam logic [3:0] PH_NAME     = 4'd1;
  localparam logic [3:0] PH_NAME_WS  = 4'd2;
  localparam logic [3:0] PH_EQ_WS    = 4'd3;
  localparam logic [3:0] PH_TOKEN    = 4'd4;
  localparam logic [3:0] PH_TOKEN_WS = 4'd5;
  localparam logic [3:0] PH_QUOTED   = 4'd6;
  localparam logic [3:0] PH_QESC     = 4'd7;
  localparam logic [3:0] PH_QCLOSED  = 4'd8;

  logic [3:0] phase_q, phase_d, phase_n;
  err_e       err_q, err_d, err_n;
  logic       term_q, term_d, term_n;
  pos_t       pos_q, pos_d, pos_n;
  pos_t       nb_q, nb_d, nb_n;
  pos_t       nf_q, nf_d, nf_n;
  pos_t       vb_q, vb_d, vb_n;
  pos_t       vf_q, vf_d, vf_n;
  pos_t       pos_inc;
  logic [7:0] c;
  logic       ends;
  err_e       verdict;

  assign c       = item_i.data_byte;
  assign pos_inc = pos_q + pos_t'(1);
  assign ends    = item_i.last_byte | item_i.empty_input;

  // State after this word's byte, before any end-of-string reset.
  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    term_d  = term_q;
    pos_d   = pos_q;
    nb_d    = nb_q;
    nf_d    = nf_q;
    vb_d    = vb_q;
    vf_d    = vf_q;
    if (!item_i.empty_input) begin
      if (pos_q == POS_MAX) begin
        // Position counter exhausted: the byte is only checked for terminators.
        err_d = ERR_LONG;
        if (is_term(c)) begin
          term_d = 1'b1;
        end
      end else begin
        pos_d = pos_inc;
        if (is_term(c)) begin
          term_d = 1'b1;
        end else if (err_q == ERR_NONE) begin
          case (phase_q)
            PH_LEAD: begin
              if (is_token(c)) begin
                nb_d    = pos_q;
                nf_d    = pos_inc;
                phase_d = PH_NAME;
              end else if (!is_blank(c)) begin
                err_d = ERR_NAME;
              end
            end
            PH_NAME: begin
              if (is_token(c)) begin
                nf_d = pos_inc;
              end else if (is_blank(c)) begin
                phase_d = PH_NAME_WS;
              end else if (c == CH_EQUAL) begin
                phase_d = PH_EQ_WS;
              end else begin
                err_d = ERR_NAME;
              end
            end
            PH_NAME_WS: begin
              if (c == CH_EQUAL) begin
                phase_d = PH_EQ_WS;
              end else if (!is_blank(c)) begin
                err_d = ERR_NAME;
              end
            end
            PH_EQ_WS: begin
              if (!is_blank(c)) begin
                vb_d = pos_q;
                vf_d = pos_inc;
                if (c == CH_DQUOTE) begin
                  phase_d = PH_QUOTED;
                end else if (is_token(c)) begin
                  phase_d = PH_TOKEN;
                end else begin
                  err_d = ERR_TOKEN;
                end
              end
            end
            PH_TOKEN: begin
              if (is_token(c)) begin
                vf_d = pos_inc;
              end else if (is_blank(c)) begin
                phase_d = PH_TOKEN_WS;
              end else begin
                err_d = ERR_TOKEN;
              end
            end
            PH_TOKEN_WS: begin
              if (!is_blank(c)) begin
                err_d = ERR_TOKEN;
              end
            end
            PH_QUOTED: begin
              if (c == CH_BSLASH) begin
                phase_d = PH_QESC;
              end else if (c == CH_DQUOTE) begin
                vf_d    = pos_inc;
                phase_d = PH_QCLOSED;
              end
            end
            PH_QESC: begin
              phase_d = PH_QUOTED;
            end
            PH_QCLOSED: begin
              if (!is_blank(c)) begin
                err_d = ERR_QUOTED;
              end
            end
            default: begin
              err_d = ERR_NAME;
            end
          endcase
        end
      end
    end
  end

  // Verdict: terminator beats any stored error, which beats the end-phase checks.
  always_comb begin
    if (term_d) begin
      verdict = ERR_TERM;
    end else if (err_d != ERR_NONE) begin
      verdict = err_d;
    end else begin
      case (phase_d)
        PH_LEAD:   verdict = ERR_BLANK;
        PH_EQ_WS:  verdict = ERR_MISSING;
        PH_QUOTED,
        PH_QESC:   verdict = ERR_QUOTED;
        default:   verdict = ERR_NONE;
      endcase
    end
  end

  // Result word; every field but the error code is zero on a rejected string.
  always_comb begin
    result_o            = '0;
    result_o.error_code = verdict;
    if (verdict == ERR_NONE) begin
      result_o.verdict_ok  = 1'b1;
      result_o.name_start  = to_opos(nb_d);
      result_o.name_length = to_opos(nf_d - nb_d);
      if (phase_d != PH_NAME && phase_d != PH_NAME_WS) begin
        result_o.has_value    = 1'b1;
        result_o.value_start  = to_opos(vb_d);
        result_o.value_length = to_opos(vf_d - vb_d);
        result_o.value_quoted = (phase_d == PH_QCLOSED);
      end
    end
  end

  // The state returns to its reset values once a string has been judged.
  always_comb begin
    phase_n = phase_d;
    err_n   = err_d;
    term_n  = term_d;
    pos_n   = pos_d;
    nb_n    = nb_d;
    nf_n    = nf_d;
    vb_n    = vb_d;
    vf_n    = vf_d;
    if (ends) begin
      phase_n = PH_LEAD;
      err_n   = ERR_NONE;
      term_n  = 1'b0;
      pos_n   = '0;
      nb_n    = '0;
      nf_n    = '0;
      vb_n    = '0;
      vf_n    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      err_q   <= ERR_NONE;
      term_q  <= 1'b0;
      pos_q   <= '0;
      nb_q    <= '0;
      nf_q    <= '0;
      vb_q    <= '0;
      vf_q    <= '0;
    end else if (advance_i) begin
      phase_q <= phase_n;
      err_q   <= err_n;
      term_q  <= term_n;
      pos_q   <= pos_n;
      nb_q    <= nb_n;
      nf_q    <= nf_n;
      vb_q    <= vb_n;
      vf_q    <= vf_n;
    end
  end

endmodule
